### hdl/lfu_pkg.sv
package lfu_pkg;

   localparam int ENTRIES = 16;
   localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int KEY_W = 32;
   localparam int VALUE_W = 31;
   localparam int COUNT_W = 16;
   localparam int STAMP_W = 32;
   localparam int CAP_W = 5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef struct packed {
      logic operation;
      logic [KEY_W-1:0] lookup_key;
      logic [VALUE_W-1:0] store_value;
   } req_type;

   typedef struct packed {
      logic found;
      logic [VALUE_W-1:0] read_value;
      logic evicted;
      logic [KEY_W-1:0] evicted_key;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] use_count;
      logic [STAMP_W-1:0] touch_stamp;
   } entry_type;

   typedef struct packed {
      logic hit;
      logic [SLOT_W-1:0] hit_slot;
      logic [VALUE_W-1:0] hit_value;
      logic [COUNT_W-1:0] hit_count;
      logic [SLOT_W-1:0] victim_slot;
      logic [KEY_W-1:0] victim_key;
      logic [SLOT_W-1:0] free_slot;
   } scan_result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

   function automatic logic [COUNT_W-1:0] count_raise(input logic [COUNT_W-1:0] count);
      logic [COUNT_W-1:0] result;
      result = (count == COUNT_MAX) ? count : count + COUNT_W'(1);
      return result;
   endfunction

endpackage

### hdl/lfu_entry_ram.sv
module lfu_entry_ram (
   input  logic clock,
   input  logic write_enable,
   input  logic [lfu_pkg::SLOT_W-1:0] write_addr,
   input  lfu_pkg::entry_type write_data,
   input  logic [lfu_pkg::SLOT_W-1:0] read_addr,
   output lfu_pkg::entry_type read_data
);
   import lfu_pkg::*;

   entry_type mem [ENTRIES];
   entry_type read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
      read_data_ff <= mem[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

### hdl/lfu_scan.sv
module lfu_scan (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic sample,
   input  logic [lfu_pkg::SLOT_W-1:0] slot,
   input  lfu_pkg::entry_type entry,
   input  logic entry_valid,
   input  logic [lfu_pkg::KEY_W-1:0] lookup_key,
   input  logic [lfu_pkg::STAMP_W-1:0] access_clock,
   output lfu_pkg::scan_result_type result
);
   import lfu_pkg::*;

   logic hit_ff;
   logic have_ff;
   logic free_found_ff;
   logic [SLOT_W-1:0] hit_slot_ff;
   logic [VALUE_W-1:0] hit_value_ff;
   logic [COUNT_W-1:0] hit_count_ff;
   logic [SLOT_W-1:0] victim_slot_ff;
   logic [KEY_W-1:0] victim_key_ff;
   logic [COUNT_W-1:0] best_count_ff;
   logic [STAMP_W-1:0] best_age_ff;
   logic [SLOT_W-1:0] free_slot_ff;

   logic [STAMP_W-1:0] age;
   logic match;
   logic better;

   // age wraps modulo 2^32 with the access clock
   assign age = access_clock - entry.touch_stamp;
   assign match = entry_valid && (entry.key == lookup_key);
   assign better = !have_ff || (entry.use_count < best_count_ff) ||
                   ((entry.use_count == best_count_ff) && (age > best_age_ff));

   always_ff @(posedge clock) begin
      if (reset || start) begin
         hit_ff <= 1'b0;
         have_ff <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (sample) begin
         if (match && !hit_ff) begin
            hit_ff <= 1'b1;
         end
         if (entry_valid && better) begin
            have_ff <= 1'b1;
         end
         if (!entry_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   // first match, strict improvement and first hole keep the lowest slot
   always_ff @(posedge clock) begin
      if (sample) begin
         if (match && !hit_ff) begin
            hit_slot_ff <= slot;
            hit_value_ff <= entry.value;
            hit_count_ff <= entry.use_count;
         end
         if (entry_valid && better) begin
            victim_slot_ff <= slot;
            victim_key_ff <= entry.key;
            best_count_ff <= entry.use_count;
            best_age_ff <= age;
         end
         if (!entry_valid && !free_found_ff) begin
            free_slot_ff <= slot;
         end
      end
   end

   always_comb begin
      result.hit = hit_ff;
      result.hit_slot = hit_slot_ff;
      result.hit_value = hit_value_ff;
      result.hit_count = hit_count_ff;
      result.victim_slot = victim_slot_ff;
      result.victim_key = victim_key_ff;
      result.free_slot = free_slot_ff;
   end

endmodule

### hdl/lfu_cache_lru_tiebreak_unit.sv
// Fully associative key-value cache, least-frequently-used replacement with
// least-recent use breaking ties. Each request passes through the transfer
// cycle, which also issues the read of the first entry, a scan streaming
// every entry out of the single-read-port entry memory for key match and victim
// choice, and a write-back step that loads the result. The result sits in
// an output register; a new request is taken while it waits, but its write-back
// holds until the earlier result has been transferred. Valid bits live in
// flip-flops, so the block is ready straight out of reset. csr_write_data sets
// the usable capacity (reset 16, values above 16 act as 16, zero makes every
// put a no-op).
module lfu_cache_lru_tiebreak_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  lfu_pkg::req_type req_payload,
   output logic rsp_valid,
   input  logic rsp_ready,
   output lfu_pkg::rsp_type rsp_payload,
   input  logic csr_write_enable,
   input  logic [lfu_pkg::CAP_W-1:0] csr_write_data
);
   import lfu_pkg::*;

   state_type state_ff, state_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   req_type req_ff, req_in;
   logic [STAMP_W-1:0] clock_ff, clock_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CAP_W-1:0] capacity_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic ram_we;
   logic [SLOT_W-1:0] ram_waddr;
   entry_type ram_wdata;
   logic [SLOT_W-1:0] ram_raddr;
   entry_type ram_rdata;

   logic scan_start;
   logic scan_sample;
   scan_result_type scan;
   logic [CNT_W-1:0] cap_eff;
   logic [SLOT_W-1:0] ins_slot;

   lfu_entry_ram u_ram (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (ram_waddr),
      .write_data   (ram_wdata),
      .read_addr    (ram_raddr),
      .read_data    (ram_rdata)
   );

   lfu_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .start        (scan_start),
      .sample       (scan_sample),
      .slot         (slot_ff),
      .entry        (ram_rdata),
      .entry_valid  (valid_ff[slot_ff]),
      .lookup_key   (req_ff.lookup_key),
      .access_clock (clock_ff),
      .result       (scan)
   );

   assign cap_eff = (int'(capacity_ff) > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(capacity_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff <= '0;
         clock_ff <= '0;
         used_ff <= '0;
         valid_ff <= '0;
         capacity_ff <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         slot_ff <= slot_in;
         clock_ff <= clock_in;
         used_ff <= used_in;
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in = state_ff;
      slot_in = slot_ff;
      req_in = req_ff;
      clock_in = clock_ff;
      used_in = used_ff;
      valid_in = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      req_ready = 1'b0;
      ram_we = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_raddr = slot_ff + SLOT_W'(1);
      scan_start = 1'b0;
      scan_sample = 1'b0;
      ins_slot = scan.free_slot;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ram_raddr = '0;
            if (req_valid) begin
               req_in = req_payload;
               scan_start = 1'b1;
               slot_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_sample = 1'b1;
            slot_in = slot_ff + SLOT_W'(1);
            if (slot_ff == SLOT_W'(ENTRIES - 1)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            // hold the write-back until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               ram_wdata.key = req_ff.lookup_key;
               ram_wdata.touch_stamp = clock_ff;
               if (req_ff.operation == OP_GET) begin
                  if (scan.hit) begin
                     rsp_in.found = 1'b1;
                     rsp_in.read_value = scan.hit_value;
                     ram_we = 1'b1;
                     ram_waddr = scan.hit_slot;
                     ram_wdata.value = scan.hit_value;
                     ram_wdata.use_count = count_raise(scan.hit_count);
                     clock_in = clock_ff + STAMP_W'(1);
                  end
               end else if (cap_eff != '0) begin
                  ram_we = 1'b1;
                  ram_wdata.value = req_ff.store_value;
                  clock_in = clock_ff + STAMP_W'(1);
                  if (scan.hit) begin
                     rsp_in.found = 1'b1;
                     ram_waddr = scan.hit_slot;
                     ram_wdata.use_count = count_raise(scan.hit_count);
                  end else begin
                     if (used_ff >= cap_eff) begin
                        ins_slot = scan.victim_slot;
                        rsp_in.evicted = 1'b1;
                        rsp_in.evicted_key = scan.victim_key;
                     end else begin
                        used_in = used_ff + CNT_W'(1);
                     end
                     ram_waddr = ins_slot;
                     ram_wdata.use_count = COUNT_W'(1);
                     valid_in[ins_slot] = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### hdl/lfu_checker.sv
module lfu_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  lfu_pkg::rsp_type rsp_payload
);
   import lfu_pkg::*;

   // a pending result is never dropped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   // one request at a time: no new transfer straight after one
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in flight");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.found |-> rsp_payload.read_value == '0)
      else $error("read value non-zero without a hit");

   a_evict_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.evicted |-> rsp_payload.evicted_key == '0)
      else $error("evicted key non-zero without eviction");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.found && rsp_payload.evicted))
      else $error("hit and eviction in one result");

endmodule

bind lfu_cache_lru_tiebreak_unit lfu_checker u_lfu_checker (.*);

### tb/tb_lfu_cache_lru_tiebreak_unit.sv
`timescale 1ns / 1ps

module tb_lfu_cache_lru_tiebreak_unit;
   import lfu_pkg::*;

   localparam int CLK_PERIOD = 4;
   localparam int RESET_CYCLES = 5;
   localparam int SETTLE_CYCLES = 40;
   localparam int PRESSURE_HOLD = 400;
   localparam int QUIET_LIMIT = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_write_enable = 1'b0;
   logic [CAP_W-1:0] csr_write_data = '0;

   lfu_cache_lru_tiebreak_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // shadow copy of the cache contents
   entry_type shadow [ENTRIES];
   logic shadow_valid [ENTRIES];
   logic [STAMP_W-1:0] shadow_clock;
   logic [CAP_W-1:0] shadow_capacity;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   logic [KEY_W-1:0] key_pool [$];

   logic full_rate = 1'b0;
   bit force_full = 1'b0;
   int req_gap = 0;
   int rsp_stall = 0;
   int requests_sent = 0;
   int results_seen = 0;
   int hits_seen = 0;
   int evictions_seen = 0;
   int settings_used = 0;
   int error_count = 0;

   function automatic void touch_entry(int slot, bit raise);
      if (raise && shadow[slot].use_count != COUNT_MAX)
         shadow[slot].use_count = shadow[slot].use_count + COUNT_W'(1);
      shadow[slot].touch_stamp = shadow_clock;
      shadow_clock = shadow_clock + STAMP_W'(1);
   endfunction

   function automatic rsp_type cache_access(req_type rq);
      rsp_type res;
      int hit_slot;
      int slot;
      int used;
      int usable;
      logic [STAMP_W-1:0] age;
      logic [STAMP_W-1:0] oldest_age;
      logic [COUNT_W-1:0] lowest_count;
      res = '0;
      usable = (shadow_capacity > ENTRIES) ? ENTRIES : int'(shadow_capacity);
      hit_slot = -1;
      used = 0;
      oldest_age = '0;
      lowest_count = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (shadow_valid[i]) begin
            used++;
            if (hit_slot < 0 && shadow[i].key == rq.lookup_key)
               hit_slot = i;
         end
      end
      if (rq.operation == OP_GET) begin
         if (hit_slot >= 0) begin
            res.found = 1'b1;
            res.read_value = shadow[hit_slot].value;
            touch_entry(hit_slot, 1'b1);
         end
      end else if (usable != 0) begin
         if (hit_slot >= 0) begin
            res.found = 1'b1;
            shadow[hit_slot].value = rq.store_value;
            touch_entry(hit_slot, 1'b1);
         end else begin
            slot = -1;
            if (used >= usable) begin
               // lowest count first, then the entry touched longest ago
               for (int i = 0; i < ENTRIES; i++) begin
                  if (shadow_valid[i]) begin
                     age = shadow_clock - shadow[i].touch_stamp;
                     if (slot < 0 || shadow[i].use_count < lowest_count ||
                         (shadow[i].use_count == lowest_count && age > oldest_age)) begin
                        slot = i;
                        lowest_count = shadow[i].use_count;
                        oldest_age = age;
                     end
                  end
               end
               res.evicted = 1'b1;
               res.evicted_key = shadow[slot].key;
            end else begin
               for (int i = 0; i < ENTRIES; i++)
                  if (slot < 0 && !shadow_valid[i])
                     slot = i;
            end
            shadow_valid[slot] = 1'b1;
            shadow[slot].key = rq.lookup_key;
            shadow[slot].value = rq.store_value;
            shadow[slot].use_count = COUNT_W'(1);
            touch_entry(slot, 1'b0);
         end
      end
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic req_type random_request();
      req_type rq;
      int r;
      rq.operation = ($urandom_range(0, 99) < 55) ? OP_PUT : OP_GET;
      r = $urandom_range(0, 99);
      if (r < 85)
         rq.lookup_key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else if (r < 95)
         // near miss: one bit away from a key in the pool
         rq.lookup_key = key_pool[$urandom_range(0, key_pool.size() - 1)] ^
                         (KEY_W'(1) << $urandom_range(0, KEY_W - 1));
      else
         rq.lookup_key = $urandom;
      r = $urandom_range(0, 19);
      rq.store_value = (r == 0) ? '0 : (r == 1) ? '1 : VALUE_W'($urandom);
      return rq;
   endfunction

   task automatic add_item(input logic op, input logic [KEY_W-1:0] key,
                           input logic [VALUE_W-1:0] value);
      req_type rq;
      rq.operation = op;
      rq.lookup_key = key;
      rq.store_value = value;
      pending_reqs.push_back(rq);
   endtask

   task automatic wait_until_drained();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic reconfigure(input int cap);
      wait_until_drained();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= CAP_W'(cap);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow_capacity = CAP_W'(cap);
      settings_used++;
   endtask

   task automatic run_phase(input int cap, input int n);
      int span;
      reconfigure(cap);
      // capacity zero keeps the old pool so gets still find live keys
      if (cap != 0) begin
         span = ((cap > ENTRIES) ? ENTRIES : cap) + int'($urandom_range(1, 6));
         key_pool.delete();
         repeat (span) key_pool.push_back($urandom);
      end
      repeat (n) pending_reqs.push_back(random_request());
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : request_driver
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsps.push_back(cache_access(req_payload));
            requests_sent++;
            if (requests_sent % 80 == 0)
               full_rate <= ($urandom_range(0, 4) == 0);
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_valid <= 1'b1;
               req_payload <= pending_reqs.pop_front();
               req_gap = (full_rate || force_full) ? 0 : pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_rsps.size() == 0) begin
               error_count++;
               $display("%0t: result with nothing expected, actual %p", $time, rsp_payload);
            end else begin
               want = expected_rsps.pop_front();
               compare_field("found", 64'(want.found), 64'(rsp_payload.found));
               compare_field("read_value", 64'(want.read_value),
                             64'(rsp_payload.read_value));
               compare_field("evicted", 64'(want.evicted), 64'(rsp_payload.evicted));
               compare_field("evicted_key", 64'(want.evicted_key),
                             64'(rsp_payload.evicted_key));
               hits_seen += int'(want.found);
               evictions_seen += int'(want.evicted);
            end
            // long hold-off so the block backs up and stalls its input
            if (results_seen == 300 || results_seen == 900)
               rsp_stall = PRESSURE_HOLD;
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!(full_rate || force_full))
               rsp_stall = pick_gap();
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      logic [KEY_W-1:0] sat_key;
      for (int i = 0; i < ENTRIES; i++) begin
         shadow_valid[i] = 1'b0;
         shadow[i] = '0;
      end
      shadow_clock = '0;
      shadow_capacity = CAP_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      add_item(OP_GET, '0, '0);                  // miss on an empty cache
      add_item(OP_PUT, '0, '1);
      add_item(OP_GET, '0, 31'h1234_5678);       // value ignored on a get
      add_item(OP_PUT, '1, '0);
      add_item(OP_PUT, '1, 31'h2AAA_AAAA);       // update of a present key
      add_item(OP_GET, '1, '0);
      add_item(OP_GET, 32'h8000_0000, '1);
      reconfigure(2);
      add_item(OP_PUT, 32'h5, 31'h5);            // lowest count goes
      add_item(OP_PUT, 32'h6, 31'h6);
      reconfigure(3);
      add_item(OP_PUT, 32'h7, 31'h7);
      add_item(OP_PUT, 32'h8, 31'h8);            // equal counts: older one goes
      reconfigure(1);                            // below the number held
      add_item(OP_GET, '1, '0);
      add_item(OP_GET, 32'h7, '0);
      add_item(OP_PUT, 32'h9, 31'h9);
      add_item(OP_PUT, 32'hA, 31'hA);
      reconfigure(0);
      add_item(OP_PUT, '1, 31'h5555_5555);       // present key, still ignored
      add_item(OP_PUT, 32'hB, 31'hB);
      add_item(OP_GET, '1, '0);
      add_item(OP_GET, 32'hA, '0);

      run_phase(16, 260);
      run_phase(4, 220);
      run_phase(31, 260);
      run_phase(1, 120);
      run_phase(0, 40);
      run_phase(9, 220);
      run_phase(17, 200);

      // hammer one key at full rate; its high count keeps it past the newcomers
      reconfigure(2);
      force_full = 1'b1;
      sat_key = $urandom;
      add_item(OP_PUT, sat_key, VALUE_W'($urandom));
      repeat (24) add_item(OP_GET, sat_key, '0);
      add_item(OP_PUT, sat_key ^ KEY_W'(1), VALUE_W'($urandom));
      add_item(OP_PUT, ~sat_key, VALUE_W'($urandom));
      add_item(OP_PUT, sat_key ^ KEY_W'(2), VALUE_W'($urandom));
      add_item(OP_GET, sat_key, '0);

      wait_until_drained();
      $display("Covered %0d requests, %0d results, %0d hits, %0d evictions over %0d settings,",
               requests_sent, results_seen, hits_seen, evictions_seen, settings_used);
      $display("with capacity 0, 1 and above 16, a hot key at full rate and output back-pressure.");
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### lfu_cache_lru_tiebreak_unit.f
hdl/lfu_pkg.sv
hdl/lfu_entry_ram.sv
hdl/lfu_scan.sv
hdl/lfu_cache_lru_tiebreak_unit.sv
hdl/lfu_checker.sv
tb/tb_lfu_cache_lru_tiebreak_unit.sv
